### src/swm_pkg.sv
// Shared constants and types for the sliding window maximum block.
// Used by swm_cell, swm_node and sliding_window_maximum; depends on nothing.
package swm_pkg;

   localparam int MAX_WINDOW   = 64;
   localparam int SAMPLE_WIDTH = 16;
   localparam int POS_WIDTH    = 16;
   localparam int CFG_WIDTH    = 7;

   localparam int TREE_LEVELS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int TREE_LEAVES = 1 << TREE_LEVELS;

   localparam int K_WIDTH = ($clog2(MAX_WINDOW + 1) > CFG_WIDTH) ?
                            $clog2(MAX_WINDOW + 1) : CFG_WIDTH;

   localparam int REQ_DATA_WIDTH = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_WIDTH = ((SAMPLE_WIDTH + POS_WIDTH + 7) / 8) * 8;

   typedef struct packed {
      logic                           alive;
      logic signed [SAMPLE_WIDTH-1:0] value;
   } cand_type;

   typedef struct packed {
      logic                 emit;
      logic [POS_WIDTH-1:0] start;
   } meta_type;

endpackage

### src/swm_cell.sv
// One cell of the candidate chain: holds one past sample and its alive flag.
// Depends on swm_pkg.
module swm_cell import swm_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           shift_en,
   input  logic                           clear,
   input  logic                           expire,
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   input  cand_type                       cand_in,
   output cand_type                       state
);

   logic                           alive_ff;
   logic                           alive_in;
   logic signed [SAMPLE_WIDTH-1:0] value_ff;

   // drop the neighbor's entry if it left the window, is smaller, or a new run starts
   assign alive_in = cand_in.alive & ~clear & ~expire & ~(sample > cand_in.value);

   always_ff @(posedge clock) begin
      if (reset) begin
         alive_ff <= 1'b0;
      end else if (shift_en) begin
         alive_ff <= alive_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         value_ff <= cand_in.value;
      end
   end

   assign state.alive = alive_ff;
   assign state.value = value_ff;

endmodule

### src/swm_node.sv
// Registered node of the maximum tree: keeps the larger of two live candidates.
// Depends on swm_pkg.
module swm_node import swm_pkg::*; (
   input  logic     clock,
   input  logic     advance,
   input  cand_type left,
   input  cand_type right,
   output cand_type result
);

   cand_type result_ff;
   cand_type result_in;
   logic     take_left;

   assign take_left = left.alive & (~right.alive | (left.value >= right.value));

   always_comb begin
      result_in.alive = left.alive | right.alive;
      result_in.value = take_left ? left.value : right.value;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

### src/sliding_window_maximum.sv
// Top level of the sliding window maximum block.
// Depends on swm_pkg, swm_cell and swm_node.
//
// Takes one sample a cycle and returns, once window_size samples of the current
// sequence have arrived, the maximum of the last window_size samples together
// with the position of the window's first sample. Each sample shifts into a
// chain of MAX_WINDOW cells; cells whose sample is smaller than a newer one, or
// older than the window, are marked dead. A registered maximum tree of
// TREE_LEVELS levels over the cells gives the result, one result a cycle at
// full rate. The whole pipeline holds while a result waits on rsp_tready.
// window_size resets to 1, zero acts as 1 and values above MAX_WINDOW saturate;
// write it only while the block is idle.
module sliding_window_maximum import swm_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,   // [15:0] sample
   input  logic                      req_tuser,   // [0] new_sequence
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,   // [15:0] window_max, [31:16] window_start
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CFG_WIDTH-1:0]      csr_data     // [6:0] window_size
);

   logic [CFG_WIDTH-1:0]           window_size_ff;
   logic [K_WIDTH-1:0]             k_eff;
   logic [POS_WIDTH-1:0]           pos_ff;
   logic [POS_WIDTH-1:0]           pos_cur;
   logic                           filled_ff;
   logic                           filled_in;
   logic                           advance;
   logic                           accept;
   logic                           new_seq;
   logic signed [SAMPLE_WIDTH-1:0] sample;
   meta_type                       meta_in;
   meta_type                       meta_ff [0:TREE_LEVELS];
   cand_type                       cell_state [0:MAX_WINDOW-1];
   cand_type                       tree [1:2*TREE_LEAVES-1];

   assign sample    = req_tdata[SAMPLE_WIDTH-1:0];
   assign new_seq   = req_tuser;
   assign csr_ready = 1'b1;

   assign advance    = ~meta_ff[TREE_LEVELS].emit | rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid & advance;

   always_comb begin
      if (window_size_ff == '0) begin
         k_eff = K_WIDTH'(1);
      end else if (K_WIDTH'(window_size_ff) > K_WIDTH'(MAX_WINDOW)) begin
         k_eff = K_WIDTH'(MAX_WINDOW);
      end else begin
         k_eff = K_WIDTH'(window_size_ff);
      end
   end

   assign pos_cur   = new_seq ? '0 : pos_ff;
   assign filled_in = (~new_seq & filled_ff) |
                      (({1'b0, pos_cur} + (POS_WIDTH+1)'(1)) >= (POS_WIDTH+1)'(k_eff));

   always_comb begin
      meta_in.emit  = accept & filled_in;
      meta_in.start = pos_cur + POS_WIDTH'(1) - POS_WIDTH'(k_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= CFG_WIDTH'(1);
      end else if (csr_valid) begin
         window_size_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         filled_ff <= 1'b0;
      end else if (accept) begin
         pos_ff    <= pos_cur + POS_WIDTH'(1);
         filled_ff <= filled_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= TREE_LEVELS; i++) begin
            meta_ff[i] <= '0;
         end
      end else if (advance) begin
         meta_ff[0] <= meta_in;
         for (int i = 1; i <= TREE_LEVELS; i++) begin
            meta_ff[i] <= meta_ff[i-1];
         end
      end
   end

   genvar j;
   generate
      for (j = 0; j < MAX_WINDOW; j++) begin : g_cell
         cand_type cand_in;
         logic     clear;
         logic     expire;

         if (j == 0) begin : g_head
            assign cand_in.alive = 1'b1;
            assign cand_in.value = sample;
            assign clear         = 1'b0;
         end else begin : g_body
            assign cand_in = cell_state[j-1];
            assign clear   = new_seq;
         end

         assign expire = (K_WIDTH'(j) >= k_eff);

         swm_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (accept),
            .clear    (clear),
            .expire   (expire),
            .sample   (sample),
            .cand_in  (cand_in),
            .state    (cell_state[j])
         );

         assign tree[TREE_LEAVES + j] = cell_state[j];
      end

      for (j = MAX_WINDOW; j < TREE_LEAVES; j++) begin : g_pad
         assign tree[TREE_LEAVES + j] = '0;
      end

      for (j = 1; j < TREE_LEAVES; j++) begin : g_node
         swm_node u_node (
            .clock   (clock),
            .advance (advance),
            .left    (tree[2*j]),
            .right   (tree[2*j + 1]),
            .result  (tree[j])
         );
      end
   endgenerate

   assign rsp_tvalid = meta_ff[TREE_LEVELS].emit;
   assign rsp_tdata  = RSP_DATA_WIDTH'({meta_ff[TREE_LEVELS].start, tree[1].value});

endmodule
